FILE: rtl/core/nsta_pkg.sv
package nsta_pkg;

   localparam int SLOTS = 64;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam int REQ_W  = 3;
   localparam int PORT_W = 8;
   localparam int CHAN_W = 4;
   localparam int NOTE_W = 7;
   localparam int TIME_W = 32;
   localparam int META_W = PORT_W + CHAN_W + NOTE_W;

   localparam int SLOT_FIELD_W  = 6;
   localparam int COUNT_FIELD_W = 7;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TIME_W-1:0] DURATION_RESET = 32'd30000;

   // Request codes as they arrive on the stream.
   localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ALL_OFF  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CHAN_OFF = 3'd3;
   localparam logic [REQ_W-1:0] REQ_TICK     = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd5;

   typedef enum logic [2:0] {
      OP_NOTE_ON,
      OP_NOTE_OFF,
      OP_ALL_OFF,
      OP_CHAN_OFF,
      OP_TICK,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [CHAN_W-1:0] channel;
      logic [NOTE_W-1:0] note;
   } meta_type;

   typedef struct packed {
      op_type            op;
      meta_type          meta;
      logic [TIME_W-1:0] now;
   } cmd_type;

endpackage

FILE: rtl/core/nsta_ram.sv
module nsta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/nsta_front.sv
module nsta_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [nsta_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [nsta_pkg::REQ_W-1:0]           req_tuser,
   output logic                                 cmd_valid,
   input  logic                                 cmd_ready,
   output nsta_pkg::cmd_type                    cmd
);

   nsta_pkg::cmd_type                 q_ff [nsta_pkg::QUEUE_DEPTH];
   logic [nsta_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [nsta_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [nsta_pkg::FILL_W-1:0]       fill_ff, fill_in;
   nsta_pkg::cmd_type                 new_cmd;
   logic                              push;
   logic                              pop;

   always_comb begin
      case (req_tuser)
         nsta_pkg::REQ_NOTE_ON:  new_cmd.op = nsta_pkg::OP_NOTE_ON;
         nsta_pkg::REQ_NOTE_OFF: new_cmd.op = nsta_pkg::OP_NOTE_OFF;
         nsta_pkg::REQ_ALL_OFF:  new_cmd.op = nsta_pkg::OP_ALL_OFF;
         nsta_pkg::REQ_CHAN_OFF: new_cmd.op = nsta_pkg::OP_CHAN_OFF;
         nsta_pkg::REQ_TICK:     new_cmd.op = nsta_pkg::OP_TICK;
         nsta_pkg::REQ_CLEAR:    new_cmd.op = nsta_pkg::OP_CLEAR;
         default:                new_cmd.op = nsta_pkg::OP_NOP;
      endcase
      new_cmd.meta.port    = req_tdata[7:0];
      new_cmd.meta.channel = req_tdata[11:8];
      new_cmd.meta.note    = req_tdata[18:12];
      new_cmd.now          = req_tdata[50:19];
   end

   assign req_tready = (fill_ff != nsta_pkg::FILL_W'(nsta_pkg::QUEUE_DEPTH));
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         if (wr_ptr_ff == nsta_pkg::QPTR_W'(nsta_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == nsta_pkg::QPTR_W'(nsta_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: rtl/core/nsta_back.sv
module nsta_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [nsta_pkg::TIME_W-1:0]           duration,
   input  logic                                  cmd_valid,
   output logic                                  cmd_ready,
   input  nsta_pkg::cmd_type                     cmd,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [nsta_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type                            state_ff, state_in;
   nsta_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [nsta_pkg::TIME_W-1:0]          cur_time_ff, cur_time_in;
   logic [nsta_pkg::SLOTS-1:0]           active_ff, active_in;
   logic [nsta_pkg::SLOTS-1:0]           ended_ff, ended_in;
   logic [nsta_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [nsta_pkg::IDX_W-1:0]           issue_idx_ff, issue_idx_in;
   logic                                 issue_on_ff, issue_on_in;
   logic [nsta_pkg::IDX_W-1:0]           eval_idx_ff, eval_idx_in;
   logic                                 eval_on_ff, eval_on_in;
   logic                                 found_ff, found_in;
   logic [nsta_pkg::IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic                                 hit_act_ff, hit_act_in;
   logic [nsta_pkg::IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic [nsta_pkg::TIME_W-1:0]          best_start_ff, best_start_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [nsta_pkg::SLOT_FIELD_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                                 rsp_matched_ff, rsp_matched_in;
   logic                                 rsp_evicted_ff, rsp_evicted_in;
   logic [nsta_pkg::COUNT_FIELD_W-1:0]   rsp_count_ff, rsp_count_in;

   nsta_pkg::meta_type                   meta_rd;
   logic [nsta_pkg::META_W-1:0]          meta_rd_bits;
   logic [nsta_pkg::TIME_W-1:0]          start_rd;
   logic [nsta_pkg::TIME_W-1:0]          end_rd;
   logic                                 meta_we;
   logic                                 start_we;
   logic                                 end_we;
   logic [nsta_pkg::IDX_W-1:0]           wr_addr;
   logic [nsta_pkg::IDX_W-1:0]           end_addr;

   logic                                 act;
   logic                                 ended;
   logic [nsta_pkg::TIME_W-1:0]          age;
   logic                                 expired;
   logic                                 sounding;
   logic                                 note_hit;
   logic                                 chan_hit;
   logic                                 out_free;
   logic [nsta_pkg::IDX_W-1:0]           sel_idx;

   // Port, channel and note share one memory; start and end times are
   // written at different moments and keep memories of their own.
   nsta_ram #(.WIDTH(nsta_pkg::META_W), .DEPTH(nsta_pkg::SLOTS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (wr_addr),
      .wr_data (cmd_ff.meta),
      .rd_addr (issue_idx_ff),
      .rd_data (meta_rd_bits)
   );

   nsta_ram #(.WIDTH(nsta_pkg::TIME_W), .DEPTH(nsta_pkg::SLOTS)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (wr_addr),
      .wr_data (cur_time_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (start_rd)
   );

   nsta_ram #(.WIDTH(nsta_pkg::TIME_W), .DEPTH(nsta_pkg::SLOTS)) u_end_ram (
      .clock   (clock),
      .wr_en   (end_we),
      .wr_addr (end_addr),
      .wr_data (cur_time_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (end_rd)
   );

   assign meta_rd  = nsta_pkg::meta_type'(meta_rd_bits);
   assign act      = active_ff[eval_idx_ff];
   assign ended    = ended_ff[eval_idx_ff];
   assign age      = cur_time_ff - end_rd;
   assign expired  = act && ended && (age > duration);
   assign sounding = act && !ended;
   assign chan_hit = (meta_rd.port == cmd_ff.meta.port) &&
                     (meta_rd.channel == cmd_ff.meta.channel);
   assign note_hit = chan_hit && (meta_rd.note == cmd_ff.meta.note);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sel_idx  = found_ff ? hit_idx_ff : best_idx_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      cur_time_in    = cur_time_ff;
      active_in      = active_ff;
      ended_in       = ended_ff;
      count_in       = count_ff;
      issue_idx_in   = issue_idx_ff;
      issue_on_in    = issue_on_ff;
      eval_idx_in    = eval_idx_ff;
      eval_on_in     = eval_on_ff;
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_act_in     = hit_act_ff;
      best_idx_in    = best_idx_ff;
      best_start_in  = best_start_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_count_in   = rsp_count_ff;
      cmd_ready      = 1'b0;
      meta_we        = 1'b0;
      start_we       = 1'b0;
      end_we         = 1'b0;
      wr_addr        = sel_idx;
      end_addr       = eval_idx_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            eval_on_in = 1'b0;
            if (cmd_valid) begin
               cmd_ready    = 1'b1;
               cmd_in       = cmd;
               found_in     = 1'b0;
               issue_idx_in = '0;
               issue_on_in  = 1'b1;
               if (cmd.op == nsta_pkg::OP_TICK) begin
                  cur_time_in = cmd.now;
               end
               if (cmd.op == nsta_pkg::OP_CLEAR || cmd.op == nsta_pkg::OP_NOP) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Reads are issued one slot ahead of the evaluation that uses them.
            if (issue_on_ff) begin
               eval_on_in  = 1'b1;
               eval_idx_in = issue_idx_ff;
               if (issue_idx_ff == nsta_pkg::IDX_W'(nsta_pkg::SLOTS - 1)) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end else begin
               eval_on_in = 1'b0;
            end

            if (eval_on_ff) begin
               case (cmd_ff.op)
                  nsta_pkg::OP_NOTE_ON: begin
                     if (!found_ff && (!act || expired)) begin
                        found_in   = 1'b1;
                        hit_idx_in = eval_idx_ff;
                        hit_act_in = act;
                     end
                     // Only used when every slot is active, so start is valid.
                     if (eval_idx_ff == '0 || start_rd < best_start_ff) begin
                        best_idx_in   = eval_idx_ff;
                        best_start_in = start_rd;
                     end
                  end
                  nsta_pkg::OP_NOTE_OFF: begin
                     if (!found_ff && sounding && note_hit) begin
                        found_in   = 1'b1;
                        hit_idx_in = eval_idx_ff;
                     end
                  end
                  nsta_pkg::OP_ALL_OFF, nsta_pkg::OP_CHAN_OFF: begin
                     if (sounding && (cmd_ff.op == nsta_pkg::OP_ALL_OFF || chan_hit)) begin
                        ended_in[eval_idx_ff] = 1'b1;
                        end_we                = 1'b1;
                     end
                  end
                  nsta_pkg::OP_TICK: begin
                     if (expired) begin
                        active_in[eval_idx_ff] = 1'b0;
                        ended_in[eval_idx_ff]  = 1'b0;
                        count_in               = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (eval_idx_ff == nsta_pkg::IDX_W'(nsta_pkg::SLOTS - 1)) begin
                  state_in = ST_COMMIT;
               end
            end
         end

         ST_COMMIT: begin
            if (out_free) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = '0;
               rsp_matched_in = 1'b0;
               rsp_evicted_in = 1'b0;
               case (cmd_ff.op)
                  nsta_pkg::OP_NOTE_ON: begin
                     active_in[sel_idx] = 1'b1;
                     ended_in[sel_idx]  = 1'b0;
                     meta_we            = 1'b1;
                     start_we           = 1'b1;
                     if (found_ff && !hit_act_ff) begin
                        count_in = count_ff + 1'b1;
                     end
                     rsp_slot_in    = nsta_pkg::SLOT_FIELD_W'(sel_idx);
                     rsp_evicted_in = !found_ff;
                  end
                  nsta_pkg::OP_NOTE_OFF: begin
                     if (found_ff) begin
                        ended_in[hit_idx_ff] = 1'b1;
                        end_we               = 1'b1;
                        end_addr             = hit_idx_ff;
                        rsp_slot_in          = nsta_pkg::SLOT_FIELD_W'(hit_idx_ff);
                        rsp_matched_in       = 1'b1;
                     end
                  end
                  nsta_pkg::OP_CLEAR: begin
                     active_in = '0;
                     ended_in  = '0;
                     count_in  = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = nsta_pkg::COUNT_FIELD_W'(count_in);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_time_ff  <= '0;
         active_ff    <= '0;
         ended_ff     <= '0;
         count_ff     <= '0;
         issue_on_ff  <= 1'b0;
         eval_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_time_ff  <= cur_time_in;
         active_ff    <= active_in;
         ended_ff     <= ended_in;
         count_ff     <= count_in;
         issue_on_ff  <= issue_on_in;
         eval_on_ff   <= eval_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      issue_idx_ff   <= issue_idx_in;
      eval_idx_ff    <= eval_idx_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_act_ff     <= hit_act_in;
      best_idx_ff    <= best_idx_in;
      best_start_ff  <= best_start_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_evicted_ff, rsp_matched_ff, rsp_slot_ff};

endmodule

FILE: rtl/core/note_slot_table_allocator.sv
// A word taken on req is queued, then scanned over every slot at one slot-table
// memory read per cycle and answered on rsp from the commit state; clear and
// unused codes skip the scan. A new word enters the scan only after the last is
// answered; a two-word queue keeps req open while the scan and rsp are busy.
// Reset (synchronous, active high) empties every slot, zeroes the time and loads
// the display duration with 30000; slot memories need no clearing pass.
module note_slot_table_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // port[7:0], channel[11:8], note[18:12], now_ms[50:19], zero fill above
   input  logic [nsta_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type[2:0]
   input  logic [nsta_pkg::REQ_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // slot[5:0], matched[6], evicted[7], active_count[14:8], zero fill above
   output logic [nsta_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [nsta_pkg::TIME_W-1:0]        csr_wdata
);

   logic [nsta_pkg::TIME_W-1:0] duration_ff;
   logic                        cmd_valid;
   logic                        cmd_ready;
   nsta_pkg::cmd_type           cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= nsta_pkg::DURATION_RESET;
      end else if (csr_we) begin
         duration_ff <= csr_wdata;
      end
   end

   nsta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   nsta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .duration   (duration_ff),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
